FILE: src/mts_pkg.sv
// Shared types, codes and helpers for the min-tracking stack.
package mts_pkg;

   localparam int DEFAULT_DEPTH = 64;

   localparam int VALUE_W = 32;
   localparam int WORD_W  = 34;

   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_POP_EMPTY  = 2'd1,
      STATUS_PUSH_FULL  = 2'd2
   } status_type;

   typedef logic signed [WORD_W-1:0]  word_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   // A stored word at or above the minimum is the plain value; a word below it
   // marks a push that set a new minimum, so the top is the minimum itself.
   function automatic value_type decode_top(input word_type word, input value_type min_v);
      word_type min_ext;
      min_ext = word_type'(min_v);
      if (word >= min_ext) begin
         decode_top = word[VALUE_W-1:0];
      end else begin
         decode_top = min_v;
      end
   endfunction

endpackage

FILE: src/min_tracking_stack.sv
// Top level of the min-tracking stack: control, entry memory and result register.
//
// A LIFO stack of signed 32-bit values that also reports its current minimum.
// An item is offered on req_command and req_value with start high and is taken
// at a rising edge where busy is low. Commands are push, pop and query; the
// unused code behaves as a query. Each item produces exactly one result on the
// rsp_ ports, marked by rsp_valid for a single cycle: the decoded top, the
// minimum, an empty flag and a status. An empty stack reports -1 for both top
// and minimum. A pop on an empty stack and a push on a full one change nothing
// and are flagged in rsp_status.
// Push, query and rejected commands return their result one cycle after the
// item is taken, and a new item may be taken every cycle. A pop that leaves
// entries behind must fetch the new top word from the entry memory, whose read
// data is registered, so it holds busy high for one cycle and answers from
// ST_POP_READ; no new item is taken while such a pop waits on its read data.
// The memory stores minimum-relative encoded words; the top word is kept in a
// register, so only pops use the memory's read data. Reset empties the stack at once with
// no clearing pass; memory contents are never used before being written.
// The receiver cannot stall; each result is presented for exactly one cycle.
module min_tracking_stack
   import mts_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_command,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                    rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_top_value,
   output logic signed [VALUE_W-1:0] rsp_min_value,
   output logic                    rsp_is_empty,
   output logic [1:0]              rsp_status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // One-hot control states: waiting for an item, or waiting on a memory read.
   typedef enum logic [1:0] {
      ST_IDLE     = 2'b01,
      ST_POP_READ = 2'b10
   } state_type;

   state_type  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   value_type  min_ff, min_in;
   word_type   top_ff, top_in;

   logic       rsp_valid_ff, rsp_valid_in;
   value_type  rsp_top_ff, rsp_top_in;
   value_type  rsp_min_ff, rsp_min_in;
   logic       rsp_empty_ff, rsp_empty_in;
   status_type rsp_status_ff, rsp_status_in;

   // Entry memory with one write port and one registered read port.
   word_type   mem [DEPTH];
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   word_type      wr_data;
   logic [AW-1:0] rd_addr;
   word_type      rd_data_ff;
   logic [CW-1:0] count_less2;

   // The read always targets the entry below the top, which is the new top
   // after a pop; the data is used in the following cycle.
   assign count_less2 = count_ff - CW'(2);
   assign rd_addr     = count_less2[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      word_type   word_v;
      word_type   min_ext;
      value_type  new_min_v;
      logic [CW-1:0] new_count_v;
      logic       respond_v;
      status_type status_v;
      logic [CW-1:0] count_dec;

      state_in      = state_ff;
      count_in      = count_ff;
      min_in        = min_ff;
      top_in        = top_ff;
      rsp_valid_in  = 1'b0;
      rsp_top_in    = rsp_top_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = top_ff;

      word_v      = top_ff;
      new_min_v   = min_ff;
      new_count_v = count_ff;
      respond_v   = 1'b0;
      status_v    = STATUS_OK;
      min_ext     = word_type'(min_ff);
      count_dec   = count_ff - CW'(1);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               respond_v = 1'b1;
               case (req_command)
                  CMD_PUSH: begin
                     if (count_ff == FULL_COUNT) begin
                        status_v = STATUS_PUSH_FULL;
                     end else begin
                        if (count_ff == '0) begin
                           word_v    = word_type'(req_value);
                           new_min_v = req_value;
                        end else if (req_value >= min_ff) begin
                           word_v = word_type'(req_value);
                        end else begin
                           // New minimum: store 2*value - old minimum.
                           word_v    = (word_type'(req_value) <<< 1) - min_ext;
                           new_min_v = req_value;
                        end
                        new_count_v = count_ff + CW'(1);
                        wr_en       = 1'b1;
                        wr_data     = word_v;
                        top_in      = word_v;
                        min_in      = new_min_v;
                        count_in    = new_count_v;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        status_v = STATUS_POP_EMPTY;
                     end else begin
                        // An encoded top word gives back the previous minimum.
                        if (top_ff < min_ext) begin
                           new_min_v = value_type'((min_ext <<< 1) - top_ff);
                        end
                        new_count_v = count_dec;
                        min_in      = new_min_v;
                        count_in    = new_count_v;
                        if (count_dec != '0) begin
                           // Result waits for the new top word from memory.
                           respond_v = 1'b0;
                           state_in  = ST_POP_READ;
                        end
                     end
                  end
                  CMD_QUERY: begin
                     status_v = STATUS_OK;
                  end
                  default: begin
                     status_v = STATUS_OK;
                  end
               endcase
            end
         end
         ST_POP_READ: begin
            word_v    = rd_data_ff;
            top_in    = rd_data_ff;
            respond_v = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (respond_v) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_v;
         if (new_count_v == '0) begin
            rsp_top_in   = '1;
            rsp_min_in   = '1;
            rsp_empty_in = 1'b1;
         end else begin
            rsp_top_in   = decode_top(word_v, new_min_v);
            rsp_min_in   = new_min_v;
            rsp_empty_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         min_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         min_ff        <= min_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy          = (state_ff == ST_POP_READ);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_is_empty  = rsp_empty_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

FILE: tb/min_tracking_stack_test.sv
// Self-checking testbench for the min-tracking stack: directed corners plus random traffic.
`timescale 1ns / 1ps

module min_tracking_stack_test;
   import mts_pkg::*;

   // The block is built at its default depth; the shadow stack below uses the same size.
   localparam int STACK_DEPTH = DEFAULT_DEPTH;

   // A run ends in failure once this many cycles pass with neither an item taken nor a
   // result seen. Every taken item is answered without further input, and the sender's random
   // gaps are a few cycles long, so this is far beyond any correct run.
   localparam int STALL_LIMIT = 2000;

   localparam int DRAIN_CYCLES = 6;

   localparam value_type VALUE_MAX = 32'sh7FFF_FFFF;
   localparam value_type VALUE_MIN = 32'sh8000_0000;

   // Unused command code; the block treats it as a query.
   localparam logic [1:0] CMD_SPARE = 2'd3;

   // One result as the block should present it.
   typedef struct {
      value_type  top_value;
      value_type  min_value;
      logic       is_empty;
      status_type status;
   } stack_view_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [1:0]       req_command;
   value_type        req_value;
   logic             rsp_valid;
   value_type        rsp_top_value;
   value_type        rsp_min_value;
   logic             rsp_is_empty;
   logic [1:0]       rsp_status;

   min_tracking_stack #(
      .DEPTH(STACK_DEPTH)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_top_value(rsp_top_value),
      .rsp_min_value(rsp_min_value),
      .rsp_is_empty (rsp_is_empty),
      .rsp_status   (rsp_status)
   );

   // Shadow copy of the stack: the stored words in the same minimum-relative encoding the
   // block uses, the number of stored elements, and the running minimum.
   word_type    shadow_words [STACK_DEPTH];
   int          shadow_depth;
   value_type   shadow_min;

   // Views predicted for items already taken, oldest first.
   stack_view_type pending_views [$];

   // Percentage of cycles in which the sender holds back its next item.
   int          sender_idle_pct;

   int          mismatch_count;
   int          results_checked;
   int          stall_cycles;
   int          push_count;
   int          pop_count;
   int          query_count;
   int          pop_empty_count;
   int          push_full_count;
   int          deepest_stack;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one item to the shadow stack and returns the view that should follow it.
   function automatic stack_view_type predict_stack_step(input logic [1:0] cmd,
                                                         input value_type val);
      stack_view_type view;
      word_type    word;
      view.status = STATUS_OK;
      case (cmd)
         CMD_PUSH: begin
            if (shadow_depth >= STACK_DEPTH) begin
               view.status = STATUS_PUSH_FULL;
            end else if (shadow_depth == 0) begin
               // The first element becomes the minimum; any stale minimum is dropped.
               shadow_words[0] = word_type'(val);
               shadow_min      = val;
               shadow_depth    = 1;
            end else if (val >= shadow_min) begin
               shadow_words[shadow_depth] = word_type'(val);
               shadow_depth++;
            end else begin
               // A new minimum: store 2*value - old minimum, which lands below the new one.
               shadow_words[shadow_depth] =
                  word_type'(2 * longint'(val) - longint'(shadow_min));
               shadow_min = val;
               shadow_depth++;
            end
         end
         CMD_POP: begin
            if (shadow_depth == 0) begin
               view.status = STATUS_POP_EMPTY;
            end else begin
               word = shadow_words[shadow_depth-1];
               // A word below the minimum marks where the minimum was set; undo it.
               if (longint'(word) < longint'(shadow_min)) begin
                  shadow_min = value_type'(2 * longint'(shadow_min) - longint'(word));
               end
               shadow_depth--;
            end
         end
         default: begin
            // Query and the unused code leave the stack alone.
         end
      endcase

      if (shadow_depth == 0) begin
         view.top_value = -1;
         view.min_value = -1;
         view.is_empty  = 1'b1;
      end else begin
         word           = shadow_words[shadow_depth-1];
         view.top_value = (longint'(word) >= longint'(shadow_min)) ? value_type'(word)
                                                                   : shadow_min;
         view.min_value = shadow_min;
         view.is_empty  = 1'b0;
      end
      return view;
   endfunction

   // Draws a push value. Besides fully random words it favors the extremes, a small range
   // that produces many equal values, and values right around the current minimum, so that
   // both the plain and the encoded store paths are taken often.
   function automatic value_type pick_value();
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2:       return value_type'($urandom_range(16)) - 8;
         3:       return shadow_min + value_type'($urandom_range(2)) - 1;
         4:       return shadow_min - value_type'($urandom_range(1000));
         default: return value_type'($urandom);
      endcase
   endfunction

   // Offers one item, waits for the block to take it, and records what it should answer.
   // The inputs change only at the falling edge; start stays high from one item into the
   // next unless the sender decides to idle.
   task automatic send_item(input logic [1:0] cmd, input value_type val);
      stack_view_type view;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start       = 1'b1;
      req_command = cmd;
      req_value   = val;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      view = predict_stack_step(cmd, val);
      pending_views.insert(pending_views.size(), view);
      case (cmd)
         CMD_PUSH: push_count++;
         CMD_POP:  pop_count++;
         default:  query_count++;
      endcase
      if (cmd == CMD_PUSH && view.status == STATUS_PUSH_FULL) begin
         push_full_count++;
      end
      if (cmd == CMD_POP && view.status == STATUS_POP_EMPTY) begin
         pop_empty_count++;
      end
      if (shadow_depth > deepest_stack) begin
         deepest_stack = shadow_depth;
      end
   endtask

   // An empty stack right after reset: every command, including the unused code, must
   // report -1 for top and minimum, and a pop must be flagged.
   task automatic test_empty_stack();
      send_item(CMD_POP, 0);
      send_item(CMD_QUERY, 32'sh1234_5678);
      send_item(CMD_SPARE, 0);
      send_item(CMD_POP, VALUE_MAX);
      // A value of -1 pushed on its own must not be confused with the empty report.
      send_item(CMD_PUSH, -1);
      send_item(CMD_POP, 0);
      send_item(CMD_QUERY, 0);
   endtask

   // The widest encoded words: the largest value followed by the smallest, then repeats of
   // the minimum (stored plain) and a stale minimum left behind by a drained stack.
   task automatic test_extremes();
      send_item(CMD_PUSH, VALUE_MAX);
      send_item(CMD_PUSH, VALUE_MIN);
      send_item(CMD_PUSH, VALUE_MIN);
      send_item(CMD_PUSH, VALUE_MAX);
      send_item(CMD_SPARE, VALUE_MIN);
      send_item(CMD_POP, 0);
      send_item(CMD_POP, 0);
      send_item(CMD_POP, 0);
      send_item(CMD_QUERY, 0);
      send_item(CMD_POP, 0);
      send_item(CMD_POP, 0);
      // The minimum register still holds the old value; a push below it must replace it.
      send_item(CMD_PUSH, 32'sd100);
      send_item(CMD_PUSH, 32'sd50);
      send_item(CMD_PUSH, 32'sd50);
      send_item(CMD_PUSH, 32'sd75);
      send_item(CMD_POP, 0);
      send_item(CMD_POP, 0);
      send_item(CMD_POP, 0);
      send_item(CMD_POP, 0);
   endtask

   // Fills the stack to capacity with random content, pushes against the full stack,
   // then drains it back to empty and pops once more.
   task automatic test_full_stack();
      while (shadow_depth < STACK_DEPTH) begin
         send_item(CMD_PUSH, pick_value());
      end
      send_item(CMD_PUSH, VALUE_MIN);
      send_item(CMD_PUSH, pick_value());
      send_item(CMD_QUERY, 0);
      while (shadow_depth > 0) begin
         send_item(CMD_POP, value_type'($urandom));
      end
      send_item(CMD_POP, 0);
   endtask

   // Random traffic in episodes. Most episodes are mixed pushes and pops with a bias toward
   // pushing, so the stack spends much of its time deep; some fill it to the top or drain
   // it to the bottom so that both rejections keep occurring.
   task automatic test_random_traffic(input int idle_pct, input int item_budget);
      int sent;
      int episode;
      int steps;
      int roll;
      sender_idle_pct = idle_pct;
      sent = 0;
      while (sent < item_budget) begin
         episode = $urandom_range(9);
         if (episode == 0) begin
            steps = STACK_DEPTH - shadow_depth + $urandom_range(1, 3);
            repeat (steps) begin
               send_item(CMD_PUSH, pick_value());
            end
         end else if (episode == 1) begin
            steps = shadow_depth + $urandom_range(1, 2);
            repeat (steps) begin
               send_item(CMD_POP, value_type'($urandom));
            end
         end else begin
            steps = $urandom_range(10, 40);
            repeat (steps) begin
               roll = $urandom_range(99);
               if (roll < 52) begin
                  send_item(CMD_PUSH, pick_value());
               end else if (roll < 86) begin
                  send_item(CMD_POP, value_type'($urandom));
               end else if (roll < 95) begin
                  send_item(CMD_QUERY, value_type'($urandom));
               end else begin
                  send_item(CMD_SPARE, value_type'($urandom));
               end
            end
         end
         sent += steps;
      end
   endtask

   // Result checker: every strobed result is matched against the oldest prediction.
   always @(posedge clock) begin
      stack_view_type want;
      if (!reset && rsp_valid) begin
         results_checked++;
         if (pending_views.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: result with no item outstanding: top %0d min %0d empty %0b st %0d",
                        $realtime, rsp_top_value, rsp_min_value, rsp_is_empty, rsp_status);
            end
         end else begin
            want = pending_views.pop_front();
            if (rsp_top_value !== want.top_value || rsp_min_value !== want.min_value ||
                rsp_is_empty !== want.is_empty || rsp_status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: mismatch: top %0d/%0d min %0d/%0d empty %0b/%0b st %0d/%0d",
                           $realtime, want.top_value, rsp_top_value, want.min_value,
                           rsp_min_value, want.is_empty, rsp_is_empty, want.status,
                           rsp_status);
               end
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither an item is taken nor a result appears.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without progress", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      // Every input is known from time zero, and reset is asserted before the tests start.
      reset           = 1'b1;
      start           = 1'b0;
      req_command     = CMD_QUERY;
      req_value       = '0;
      shadow_depth    = 0;
      shadow_min      = '0;
      sender_idle_pct = 0;
      mismatch_count  = 0;
      results_checked = 0;
      stall_cycles    = 0;
      push_count      = 0;
      pop_count       = 0;
      query_count     = 0;
      pop_empty_count = 0;
      push_full_count = 0;
      deepest_stack   = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_stack();
      test_extremes();
      test_full_stack();

      // Three phases of random traffic: a lightly idling sender, a heavily idling one, and
      // back-to-back items. The receiver cannot stall, so only the sender's gaps vary.
      test_random_traffic(18, 580);
      test_random_traffic(64, 580);
      test_random_traffic(0, 580);
      test_full_stack();

      @(negedge clock);
      start = 1'b0;

      // Let the last results come out, then a few more cycles to catch any stray strobe.
      while (pending_views.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_views.size() != 0) begin
         mismatch_count++;
         $display("%0d predicted results never arrived", pending_views.size());
      end

      $display("Sent %0d pushes, %0d pops and %0d queries; %0d pops on empty, %0d pushes on full",
               push_count, pop_count, query_count, pop_empty_count, push_full_count);
      $display("Deepest stack %0d of %0d; %0d results checked, %0d mismatches",
               deepest_stack, STACK_DEPTH, results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
